// ===== rtl/core/mlfr_pkg.sv =====
// Shared types and constants for the meter-bus long-frame receiver.
package mlfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned RoleW   = 2;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned InDataW = 3 * ByteW;
  localparam int unsigned OutFldW = RoleW + ByteW + CodeW + CodeW;
  localparam int unsigned OutDataW = ((OutFldW + 7) / 8) * 8;
  localparam int unsigned ReqBeats = 5;
  localparam int unsigned BeatW   = $clog2(ReqBeats);

  localparam logic [ByteW-1:0] ShortStart = 8'h10;
  localparam logic [ByteW-1:0] LongStart  = 8'h68;
  localparam logic [ByteW-1:0] StopByte   = 8'h16;
  localparam logic [ByteW-1:0] HeadFields = 8'd3;

  typedef enum logic [KindW-1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [RoleW-1:0] {
    ROLE_TX     = 2'd0,
    ROLE_FRAME  = 2'd1,
    ROLE_STATUS = 2'd2
  } role_e;

  typedef enum logic [CodeW-1:0] {
    FLD_START1 = 4'd0,
    FLD_LEN1   = 4'd1,
    FLD_LEN2   = 4'd2,
    FLD_START2 = 4'd3,
    FLD_C      = 4'd4,
    FLD_A      = 4'd5,
    FLD_CI     = 4'd6,
    FLD_UD     = 4'd7,
    FLD_CHK    = 4'd8,
    FLD_STOP   = 4'd9
  } field_e;

  typedef enum logic [CodeW-1:0] {
    ST_BUSY         = 4'd0,
    ST_OK           = 4'd1,
    ST_BAD_START1   = 4'd2,
    ST_LEN_SHORT    = 4'd3,
    ST_LEN_MISMATCH = 4'd4,
    ST_BAD_START2   = 4'd5,
    ST_CHECKSUM     = 4'd6,
    ST_BAD_STOP     = 4'd7,
    ST_TIMEOUT      = 4'd8,
    ST_IGNORED      = 4'd9
  } status_e;

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_START1 = 12'b0000_0000_0010,
    PH_LEN1   = 12'b0000_0000_0100,
    PH_LEN2   = 12'b0000_0000_1000,
    PH_START2 = 12'b0000_0001_0000,
    PH_C      = 12'b0000_0010_0000,
    PH_A      = 12'b0000_0100_0000,
    PH_CI     = 12'b0000_1000_0000,
    PH_UD     = 12'b0001_0000_0000,
    PH_CHK    = 12'b0010_0000_0000,
    PH_STOP   = 12'b0100_0000_0000,
    PH_ERR    = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    role_e            role;
    logic [ByteW-1:0] data;
    field_e           field;
    status_e          status;
    logic             last;
    logic             req;
  } result_t;

endpackage

// ===== rtl/core/mbus_long_frame_receiver_unit.sv =====
// Meter-bus request sender and long-frame reply checker, top level.
//
// Input channel s_axis: one beat per item. tuser carries the item kind (start
// request, received byte, receive timeout); tdata carries rx_byte, command and
// address. Output channel m_axis: one beat per result; tdata carries role,
// data byte, field code and status; tlast marks the end of a request run or
// of an exchange.
// An accepted item enters an input register; from there it is checked
// against the frame state, and its result is loaded into the output register
// once that register is free, so each item passes the input register and then
// the output register before its result shows on m_axis.
// A received byte or timeout gives one result beat; a start request gives
// five transmit beats from the output register, one per cycle while m_axis_tready_i is high.
// Throughput is one item per cycle while m_axis_tready_i is high, limited only
// by the output register, which holds a start request for its five beats.
// While m_axis_tready_i is low, the output register holds and the input
// register still takes one more item before s_axis_tready_o drops.
// Reset empties both registers and returns the checker to idle.
module mbus_long_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // rx_byte [7:0], command [15:8], address [23:16]
  input  logic [mlfr_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind [1:0]
  input  logic [mlfr_pkg::KindW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // role [1:0], data_byte [9:2], field_code [13:10], status [17:14], zero fill
  output logic [mlfr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // last
  output logic                           m_axis_tlast_o
);

  localparam int unsigned BW = mlfr_pkg::ByteW;

  logic                   in_valid_q;
  mlfr_pkg::kind_e        in_kind_q;
  logic [BW-1:0]          in_byte_q, in_cmd_q, in_adr_q;

  mlfr_pkg::phase_e       phase_q, phase_d;
  logic [BW-1:0]          flen_q, flen_d;
  logic [BW-1:0]          dcnt_q, dcnt_d, dcnt_inc;
  logic [BW-1:0]          sum_q, sum_d, sum_inc;
  mlfr_pkg::status_e      err_q, err_d;

  logic                   out_valid_q;
  mlfr_pkg::result_t      out_q, res;
  logic [BW-1:0]          out_cmd_q, out_adr_q;
  logic [mlfr_pkg::BeatW-1:0] beat_q;

  logic                   final_beat, out_done, advance, load;
  mlfr_pkg::field_e       ph_field;

  mlfr_pkg::role_e        o_role;
  logic [BW-1:0]          o_data;
  mlfr_pkg::field_e       o_field;
  mlfr_pkg::status_e      o_status;
  logic                   o_last;

  assign final_beat = !out_q.req ||
                      (beat_q == mlfr_pkg::BeatW'(mlfr_pkg::ReqBeats - 1));
  assign out_done   = out_valid_q && m_axis_tready_i && final_beat;
  assign advance    = !out_valid_q || out_done;
  assign load       = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= mlfr_pkg::kind_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i[BW-1:0];
      in_cmd_q  <= s_axis_tdata_i[2*BW-1:BW];
      in_adr_q  <= s_axis_tdata_i[3*BW-1:2*BW];
    end
  end

  always_comb begin
    unique case (phase_q)
      mlfr_pkg::PH_START1: ph_field = mlfr_pkg::FLD_START1;
      mlfr_pkg::PH_LEN1:   ph_field = mlfr_pkg::FLD_LEN1;
      mlfr_pkg::PH_LEN2:   ph_field = mlfr_pkg::FLD_LEN2;
      mlfr_pkg::PH_START2: ph_field = mlfr_pkg::FLD_START2;
      mlfr_pkg::PH_C:      ph_field = mlfr_pkg::FLD_C;
      mlfr_pkg::PH_A:      ph_field = mlfr_pkg::FLD_A;
      mlfr_pkg::PH_CI:     ph_field = mlfr_pkg::FLD_CI;
      mlfr_pkg::PH_UD:     ph_field = mlfr_pkg::FLD_UD;
      mlfr_pkg::PH_CHK:    ph_field = mlfr_pkg::FLD_CHK;
      mlfr_pkg::PH_STOP:   ph_field = mlfr_pkg::FLD_STOP;
      default:             ph_field = mlfr_pkg::FLD_START1;
    endcase
  end

  assign sum_inc  = sum_q + in_byte_q;
  assign dcnt_inc = dcnt_q + BW'(1);

  always_comb begin
    phase_d = phase_q;
    flen_d  = flen_q;
    dcnt_d  = dcnt_q;
    sum_d   = sum_q;
    err_d   = err_q;
    res.role   = mlfr_pkg::ROLE_STATUS;
    res.data   = '0;
    res.field  = mlfr_pkg::FLD_START1;
    res.status = mlfr_pkg::ST_IGNORED;
    res.last   = 1'b0;
    res.req    = 1'b0;
    unique case (in_kind_q)
      mlfr_pkg::KIND_START: begin
        res.role   = mlfr_pkg::ROLE_TX;
        res.status = mlfr_pkg::ST_BUSY;
        res.req    = 1'b1;
        phase_d = mlfr_pkg::PH_START1;
        flen_d  = '0;
        dcnt_d  = '0;
        sum_d   = '0;
        err_d   = mlfr_pkg::ST_BUSY;
      end
      mlfr_pkg::KIND_TIMEOUT: begin
        if (phase_q != mlfr_pkg::PH_IDLE) begin
          res.status = (err_q != mlfr_pkg::ST_BUSY) ? err_q : mlfr_pkg::ST_TIMEOUT;
          res.field  = ph_field;
          res.last   = 1'b1;
          phase_d    = mlfr_pkg::PH_IDLE;
        end
      end
      mlfr_pkg::KIND_BYTE: begin
        res.data   = in_byte_q;
        res.field  = ph_field;
        res.role   = mlfr_pkg::ROLE_FRAME;
        res.status = mlfr_pkg::ST_BUSY;
        unique case (phase_q)
          mlfr_pkg::PH_START1: begin
            if (in_byte_q != mlfr_pkg::LongStart) res.status = mlfr_pkg::ST_BAD_START1;
            else phase_d = mlfr_pkg::PH_LEN1;
          end
          mlfr_pkg::PH_LEN1: begin
            if (in_byte_q <= mlfr_pkg::HeadFields) begin
              res.status = mlfr_pkg::ST_LEN_SHORT;
            end else begin
              flen_d  = in_byte_q;
              phase_d = mlfr_pkg::PH_LEN2;
            end
          end
          mlfr_pkg::PH_LEN2: begin
            if (in_byte_q != flen_q) res.status = mlfr_pkg::ST_LEN_MISMATCH;
            else phase_d = mlfr_pkg::PH_START2;
          end
          mlfr_pkg::PH_START2: begin
            if (in_byte_q != mlfr_pkg::LongStart) res.status = mlfr_pkg::ST_BAD_START2;
            else phase_d = mlfr_pkg::PH_C;
          end
          mlfr_pkg::PH_C: begin
            sum_d   = sum_inc;
            phase_d = mlfr_pkg::PH_A;
          end
          mlfr_pkg::PH_A: begin
            sum_d   = sum_inc;
            phase_d = mlfr_pkg::PH_CI;
          end
          mlfr_pkg::PH_CI: begin
            sum_d   = sum_inc;
            dcnt_d  = '0;
            phase_d = mlfr_pkg::PH_UD;
          end
          mlfr_pkg::PH_UD: begin
            sum_d  = sum_inc;
            dcnt_d = dcnt_inc;
            if (dcnt_inc >= flen_q - mlfr_pkg::HeadFields) phase_d = mlfr_pkg::PH_CHK;
          end
          mlfr_pkg::PH_CHK: begin
            if (in_byte_q != sum_q) res.status = mlfr_pkg::ST_CHECKSUM;
            else phase_d = mlfr_pkg::PH_STOP;
          end
          mlfr_pkg::PH_STOP: begin
            if (in_byte_q != mlfr_pkg::StopByte) begin
              res.status = mlfr_pkg::ST_BAD_STOP;
            end else begin
              res.status = mlfr_pkg::ST_OK;
              res.last   = 1'b1;
              phase_d    = mlfr_pkg::PH_IDLE;
            end
          end
          default: begin
            res.role   = mlfr_pkg::ROLE_STATUS;
            res.field  = mlfr_pkg::FLD_START1;
            res.status = mlfr_pkg::ST_IGNORED;
          end
        endcase
        if (res.role == mlfr_pkg::ROLE_FRAME && res.status != mlfr_pkg::ST_BUSY &&
            res.status != mlfr_pkg::ST_OK) begin
          res.role = mlfr_pkg::ROLE_STATUS;
          err_d    = res.status;
          phase_d  = mlfr_pkg::PH_ERR;
        end
      end
      default: begin
        res.status = mlfr_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mlfr_pkg::PH_IDLE;
      flen_q      <= '0;
      dcnt_q      <= '0;
      sum_q       <= '0;
      err_q       <= mlfr_pkg::ST_BUSY;
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      if (load) begin
        phase_q <= phase_d;
        flen_q  <= flen_d;
        dcnt_q  <= dcnt_d;
        sum_q   <= sum_d;
        err_q   <= err_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        beat_q      <= '0;
      end else if (m_axis_tready_i) begin
        beat_q <= beat_q + mlfr_pkg::BeatW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q     <= res;
      out_cmd_q <= in_cmd_q;
      out_adr_q <= in_adr_q;
    end
  end

  always_comb begin
    o_role   = out_q.role;
    o_data   = out_q.data;
    o_field  = out_q.field;
    o_status = out_q.status;
    o_last   = out_q.last;
    if (out_q.req) begin
      o_last = 1'b0;
      case (beat_q)
        mlfr_pkg::BeatW'(0): begin
          o_data  = mlfr_pkg::ShortStart;
          o_field = mlfr_pkg::FLD_START1;
        end
        mlfr_pkg::BeatW'(1): begin
          o_data  = out_cmd_q;
          o_field = mlfr_pkg::FLD_C;
        end
        mlfr_pkg::BeatW'(2): begin
          o_data  = out_adr_q;
          o_field = mlfr_pkg::FLD_A;
        end
        mlfr_pkg::BeatW'(3): begin
          o_data  = out_cmd_q + out_adr_q;
          o_field = mlfr_pkg::FLD_CHK;
        end
        default: begin
          o_data  = mlfr_pkg::StopByte;
          o_field = mlfr_pkg::FLD_STOP;
          o_last  = 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = o_last;
  assign m_axis_tdata_o  = {{(mlfr_pkg::OutDataW - mlfr_pkg::OutFldW){1'b0}},
                            o_status, o_field, o_data, o_role};

  a_req_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.req |-> beat_q < mlfr_pkg::BeatW'(mlfr_pkg::ReqBeats))
    else $error("request beat index out of range");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_kind_q) && $stable(in_byte_q))
    else $error("input register changed while stalled");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.req && out_q.last |-> phase_q == mlfr_pkg::PH_IDLE)
    else $error("exchange ended but checker not idle");

  a_err_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlfr_pkg::PH_ERR |-> err_q != mlfr_pkg::ST_BUSY)
    else $error("error phase without stored error");

endmodule
